### design/sha256_stream_hasher_macros.svh
// ============================================================================
// sha256_stream_hasher_macros.svh
// Assertion macros for the SHA-256 stream hasher. Checks compile away when
// SYNTHESIS is defined.
// ============================================================================
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define SHS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SHS_ASSERT_IMPL(label, ante, cons, msg)
`define SHS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### design/shs_pkg.sv
// ============================================================================
// shs_pkg
// Shared types, constants and tables of the SHA-256 stream hasher.
// ============================================================================
package shs_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAIN_AW    = 3;   // 8 chaining words
    localparam int BLK_AW      = 4;   // 16 words per 512-bit block
    localparam int FILL_W      = 6;   // bytes in the current block
    localparam int BLK_CNT_W   = 55;  // bit length above the block offset

    localparam logic [1:0] ACT_ABSORB     = 2'd0;
    localparam logic [1:0] ACT_ABSORB_FIN = 2'd1;
    localparam logic [1:0] ACT_FINISH     = 2'd2;

    typedef logic [WORD_W-1:0] word_t;

    // compression engine requests toward the two memories
    typedef struct packed {
        logic [CHAIN_AW-1:0] chain_raddr;
        logic                chain_we;
        logic [CHAIN_AW-1:0] chain_waddr;
        word_t               chain_wdata;
        logic [BLK_AW-1:0]   blk_raddr;
        logic                done;
    } shs_cmp_ctl_t;

    function automatic word_t ror32(input word_t x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

    function automatic word_t initial_hash(input logic [CHAIN_AW-1:0] idx);
        word_t h;
        unique case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

### design/shs_block_mem.sv
// ============================================================================
// shs_block_mem
// 16 x 32 block buffer, one write port, one registered read port.
// ============================================================================
module shs_block_mem
    import shs_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [BLK_AW-1:0] waddr,
    input  word_t             wdata,
    input  logic [BLK_AW-1:0] raddr,
    output word_t             rdata
);

    word_t mem [2**BLK_AW];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/shs_chain_mem.sv
// ============================================================================
// shs_chain_mem
// 8 x 32 chaining-word store. Per-entry valid bits; an invalid entry reads
// as the initial hash value, so a clear restarts the message.
// ============================================================================
module shs_chain_mem
    import shs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                we,
    input  logic [CHAIN_AW-1:0] waddr,
    input  word_t               wdata,
    input  logic [CHAIN_AW-1:0] raddr,
    output word_t               rdata
);

    word_t                    mem [2**CHAIN_AW];
    word_t                    data_reg;
    logic [2**CHAIN_AW-1:0]   valid_reg;
    logic                     rvalid_reg;
    logic [CHAIN_AW-1:0]      raddr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            raddr_reg  <= '0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
            raddr_reg  <= raddr;
        end
    end

    assign rdata = rvalid_reg ? data_reg : initial_hash(raddr_reg);

endmodule

### design/shs_compress.sv
// ============================================================================
// shs_compress
// SHA-256 compression sequencer: one round per cycle, rolling 16-word
// message schedule, chaining words loaded from and written back to memory.
// ============================================================================
module shs_compress
    import shs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  word_t        chain_rdata,
    input  word_t        blk_rdata,
    output shs_cmp_ctl_t ctl
);

    // step plan after start: chain words are read and shifted into a..h;
    // block words are read starting with the last chain read, and the schedule
    // step registers K+W ahead of each round; after the rounds the chain words
    // are re-read and the sums are written back to the chain memory.
    localparam logic [6:0] CYC_LOAD_FIRST  = 7'd1;
    localparam logic [6:0] CYC_LOAD_LAST   = 7'd8;
    localparam logic [6:0] CYC_BLK_FIRST   = 7'd7;
    localparam logic [6:0] CYC_SCHED_FIRST = 7'd8;
    localparam logic [6:0] CYC_SCHED_LAST  = 7'd71;
    localparam logic [6:0] CYC_ROUND_FIRST = 7'd9;
    localparam logic [6:0] CYC_ROUND_LAST  = 7'd72;
    localparam logic [6:0] CYC_WB_FIRST    = 7'd73;
    localparam logic [6:0] CYC_LAST        = 7'd80;
    localparam logic [6:0] MSG_WORDS       = 7'd16;

    logic       busy_reg;
    logic [6:0] cyc_reg;
    word_t      v_reg   [8];
    word_t      win_reg [16];
    word_t      kw_reg;

    logic       load_ph, sched_ph, round_ph, wb_ph;
    logic [6:0] sdiff, bdiff;
    word_t      s0, s1, w_new;
    word_t      big0, big1, ch, maj, t1, a_new, e_new;

    always_comb
    begin
        load_ph  = busy_reg && cyc_reg >= CYC_LOAD_FIRST && cyc_reg <= CYC_LOAD_LAST;
        sched_ph = busy_reg && cyc_reg >= CYC_SCHED_FIRST && cyc_reg <= CYC_SCHED_LAST;
        round_ph = busy_reg && cyc_reg >= CYC_ROUND_FIRST && cyc_reg <= CYC_ROUND_LAST;
        wb_ph    = busy_reg && cyc_reg >= CYC_WB_FIRST;

        sdiff = cyc_reg - CYC_SCHED_FIRST;
        bdiff = cyc_reg - CYC_BLK_FIRST;

        s0 = ror32(win_reg[1], 5'd7) ^ ror32(win_reg[1], 5'd18) ^ (win_reg[1] >> 3);
        s1 = ror32(win_reg[14], 5'd17) ^ ror32(win_reg[14], 5'd19) ^ (win_reg[14] >> 10);
        w_new = (sdiff < MSG_WORDS) ? blk_rdata : s1 + win_reg[9] + s0 + win_reg[0];

        big1  = ror32(v_reg[4], 5'd6) ^ ror32(v_reg[4], 5'd11) ^ ror32(v_reg[4], 5'd25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + kw_reg;
        big0  = ror32(v_reg[0], 5'd2) ^ ror32(v_reg[0], 5'd13) ^ ror32(v_reg[0], 5'd22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        a_new = t1 + big0 + maj;
        e_new = v_reg[3] + t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cyc_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cyc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cyc_reg == CYC_LAST)
            begin
                busy_reg <= 1'b0;
            end
            cyc_reg <= cyc_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ph)
        begin
            for (int i = 0; i < 7; i++)
            begin
                v_reg[i] <= v_reg[i+1];
            end
            v_reg[7] <= chain_rdata;
        end
        else if (round_ph)
        begin
            v_reg[0] <= a_new;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= e_new;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
        else if (wb_ph)
        begin
            // rotate so the word being written back sits in v_reg[0]
            for (int i = 0; i < 7; i++)
            begin
                v_reg[i] <= v_reg[i+1];
            end
            v_reg[7] <= v_reg[0];
        end

        if (sched_ph)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
            kw_reg      <= round_k(sdiff[5:0]) + w_new;
        end
    end

    always_comb
    begin
        ctl.chain_raddr = cyc_reg[CHAIN_AW-1:0];
        ctl.chain_we    = wb_ph;
        ctl.chain_waddr = cyc_reg[CHAIN_AW-1:0] - 3'd1;
        ctl.chain_wdata = chain_rdata + v_reg[0];
        ctl.blk_raddr   = bdiff[BLK_AW-1:0];
        ctl.done        = busy_reg && (cyc_reg == CYC_LAST);
    end

endmodule

### design/sha256_stream_hasher.sv
// ============================================================================
// sha256_stream_hasher
// Byte-stream SHA-256 engine: absorbs bytes into a block memory, compresses
// full blocks against a chaining-word memory, pads on finish and returns
// the digest as eight 32-bit words.
// ============================================================================
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  item      item_valid/item_stall, action, data_byte   in
//  digest    digest_valid/digest_stall, digest_word,    out
//            word_index, last_word
//
//  A byte that completes a block starts a compression (one round per cycle in
//  the single round unit). Finish: padding writes up to the last block word,
//  then a compression per padded block (one or two), then each digest word
//  is read through the chain memory's single read port into the output slot.
//  Reset leaves the engine idle with the initial hash; no clearing pass.
//  digest_stall only delays the digest words; item_stall is high while busy.
//
`include "sha256_stream_hasher_macros.svh"

module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PAD      = 3'd1;
    localparam logic [2:0] ST_COMP     = 3'd2;
    localparam logic [2:0] ST_OUT_READ = 3'd3;
    localparam logic [2:0] ST_OUT_LOAD = 3'd4;

    localparam logic [FILL_W-1:0]   FILL_LAST   = 6'd63;
    localparam logic [BLK_AW-1:0]   IDX_LEN_HI  = 4'd14;
    localparam logic [BLK_AW-1:0]   IDX_LEN_LO  = 4'd15;
    localparam logic [CHAIN_AW-1:0] IDX_LAST_DW = 3'd7;

    logic [2:0]           state_reg,   state_next;
    logic [FILL_W-1:0]    fill_reg,    fill_next;
    logic [BLK_CNT_W-1:0] blk_cnt_reg, blk_cnt_next;
    word_t                acc_reg,     acc_next;
    logic [BLK_AW-1:0]    pad_idx_reg, pad_idx_next;
    logic                 fin_reg,     fin_next;
    logic                 padded_reg,  padded_next;
    logic                 second_reg,  second_next;
    logic [CHAIN_AW-1:0]  out_idx_reg, out_idx_next;
    logic                 digest_valid_reg, digest_valid_next;
    word_t                digest_word_reg;
    logic [2:0]           word_index_reg;
    logic                 last_word_reg;

    logic                item_accept, is_byte, pad_extra, last_blk;
    logic                cmp_start, chain_clr;
    logic                blk_we;
    logic [BLK_AW-1:0]   blk_waddr;
    word_t               blk_wdata, blk_rdata, chain_rdata;
    logic [CHAIN_AW-1:0] chain_raddr;
    logic [1:0]          fb;
    logic [BLK_AW-1:0]   fw;
    logic [FILL_W-1:0]   fill_inc;
    logic [63:0]         total_bits;
    word_t               merged_word, head_word, pad_word;
    shs_cmp_ctl_t        cmp_ctl;

    shs_block_mem u_blk_mem (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (cmp_ctl.blk_raddr),
        .rdata (blk_rdata)
    );

    shs_chain_mem u_chain_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (chain_clr),
        .we    (cmp_ctl.chain_we),
        .waddr (cmp_ctl.chain_waddr),
        .wdata (cmp_ctl.chain_wdata),
        .raddr (chain_raddr),
        .rdata (chain_rdata)
    );

    shs_compress u_compress (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmp_start),
        .chain_rdata (chain_rdata),
        .blk_rdata   (blk_rdata),
        .ctl         (cmp_ctl)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign chain_raddr  = (state_reg == ST_OUT_READ) ? out_idx_reg : cmp_ctl.chain_raddr;

    // byte lanes: lane 0 is bits 31..24 (first byte of the word)
    always_comb
    begin
        fb         = fill_reg[1:0];
        fw         = fill_reg[FILL_W-1:2];
        fill_inc   = fill_reg + 6'd1;
        is_byte    = (action == ACT_ABSORB) || (action == ACT_ABSORB_FIN);
        pad_extra  = (fill_reg[FILL_W-1:3] == 3'b111);  // fewer than 9 bytes free
        last_blk   = second_reg || !pad_extra;
        total_bits = {blk_cnt_reg, fill_reg, 3'b000};

        for (int j = 0; j < 4; j++)
        begin
            merged_word[31-8*j -: 8] = (2'(j) == fb) ? data_byte : acc_reg[31-8*j -: 8];
            if (2'(j) < fb)
            begin
                head_word[31-8*j -: 8] = acc_reg[31-8*j -: 8];
            end
            else if (2'(j) == fb)
            begin
                head_word[31-8*j -: 8] = 8'h80;
            end
            else
            begin
                head_word[31-8*j -: 8] = 8'h00;
            end
        end

        priority if (!second_reg && pad_idx_reg == fw)
        begin
            pad_word = head_word;
        end
        else if (last_blk && pad_idx_reg == IDX_LEN_HI)
        begin
            pad_word = total_bits[63:32];
        end
        else if (last_blk && pad_idx_reg == IDX_LEN_LO)
        begin
            pad_word = total_bits[31:0];
        end
        else
        begin
            pad_word = '0;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        blk_cnt_next      = blk_cnt_reg;
        acc_next          = acc_reg;
        pad_idx_next      = pad_idx_reg;
        fin_next          = fin_reg;
        padded_next       = padded_reg;
        second_next       = second_reg;
        out_idx_next      = out_idx_reg;
        digest_valid_next = digest_valid_reg && digest_stall;
        cmp_start         = 1'b0;
        chain_clr         = 1'b0;
        blk_we            = 1'b0;
        blk_waddr         = fw;
        blk_wdata         = merged_word;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept && is_byte)
                begin
                    acc_next  = merged_word;
                    fill_next = fill_inc;
                    blk_we    = (fb == 2'd3);
                    if (fill_reg == FILL_LAST)
                    begin
                        blk_cnt_next = blk_cnt_reg + BLK_CNT_W'(1);
                        cmp_start    = 1'b1;
                        fin_next     = (action == ACT_ABSORB_FIN);
                        padded_next  = 1'b0;
                        state_next   = ST_COMP;
                    end
                    else if (action == ACT_ABSORB_FIN)
                    begin
                        pad_idx_next = fill_inc[FILL_W-1:2];
                        second_next  = 1'b0;
                        fin_next     = 1'b1;
                        state_next   = ST_PAD;
                    end
                end
                else if (item_accept && action == ACT_FINISH)
                begin
                    pad_idx_next = fw;
                    second_next  = 1'b0;
                    fin_next     = 1'b1;
                    state_next   = ST_PAD;
                end
            end

            ST_PAD:
            begin
                blk_we    = 1'b1;
                blk_waddr = pad_idx_reg;
                blk_wdata = pad_word;
                if (pad_idx_reg == IDX_LEN_LO)
                begin
                    cmp_start   = 1'b1;
                    padded_next = 1'b1;
                    state_next  = ST_COMP;
                end
                else
                begin
                    pad_idx_next = pad_idx_reg + 4'd1;
                end
            end

            ST_COMP:
            begin
                if (cmp_ctl.done)
                begin
                    priority if (!fin_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!padded_reg)
                    begin
                        // final byte closed a block: pad a fresh one
                        pad_idx_next = fw;
                        second_next  = 1'b0;
                        state_next   = ST_PAD;
                    end
                    else if (pad_extra && !second_reg)
                    begin
                        pad_idx_next = '0;
                        second_next  = 1'b1;
                        state_next   = ST_PAD;
                    end
                    else
                    begin
                        out_idx_next = '0;
                        state_next   = ST_OUT_READ;
                    end
                end
            end

            ST_OUT_READ:
            begin
                // chain read issued now; data lands next cycle in a free slot
                if (!digest_valid_reg || !digest_stall)
                begin
                    state_next = ST_OUT_LOAD;
                end
            end

            ST_OUT_LOAD:
            begin
                digest_valid_next = 1'b1;
                if (out_idx_reg == IDX_LAST_DW)
                begin
                    chain_clr    = 1'b1;
                    fill_next    = '0;
                    blk_cnt_next = '0;
                    fin_next     = 1'b0;
                    padded_next  = 1'b0;
                    second_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    state_next   = ST_OUT_READ;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_reg         <= '0;
            blk_cnt_reg      <= '0;
            pad_idx_reg      <= '0;
            fin_reg          <= 1'b0;
            padded_reg       <= 1'b0;
            second_reg       <= 1'b0;
            out_idx_reg      <= '0;
            digest_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            blk_cnt_reg      <= blk_cnt_next;
            pad_idx_reg      <= pad_idx_next;
            fin_reg          <= fin_next;
            padded_reg       <= padded_next;
            second_reg       <= second_next;
            out_idx_reg      <= out_idx_next;
            digest_valid_reg <= digest_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == ST_OUT_LOAD)
        begin
            digest_word_reg <= chain_rdata;
            word_index_reg  <= out_idx_reg;
            last_word_reg   <= (out_idx_reg == IDX_LAST_DW);
        end
    end

    assign digest_valid = digest_valid_reg;
    assign digest_word  = digest_word_reg;
    assign word_index   = word_index_reg;
    assign last_word    = last_word_reg;

    `SHS_ASSERT_IMPL(a_done_in_comp, cmp_ctl.done, state_reg == ST_COMP, "compress done outside COMP")
    `SHS_ASSERT_IMPL(a_load_free_slot, state_reg == ST_OUT_LOAD, !digest_valid_reg, "digest word overwritten")
    `SHS_ASSERT_IMPL(a_second_needs_extra, state_reg == ST_PAD && second_reg, pad_extra, "bad second pad block")
    `SHS_ASSERT_NEXT(a_fresh_message, state_reg == ST_OUT_LOAD && out_idx_reg == IDX_LAST_DW, state_reg == ST_IDLE && fill_reg == '0 && blk_cnt_reg == '0, "state not reinitialized")

endmodule
